>>> sv/brr_pkg.sv
// Package with the shared types and fixed constants of the BRR ADPCM block decoder.
package brr_pkg;

  // Working width of the prediction sum, wide enough for every filter term.
  typedef logic signed [19:0] acc_t;

  // One decoded sample as stored in the history ring and sent out.
  typedef logic signed [15:0] sample_t;

  // Position of a nybble within one data word, first to fourth.
  typedef logic [1:0] step_t;

  // Prediction filter codes taken from the block header.
  typedef enum logic [1:0] {
    FILT_NONE = 2'd0,
    FILT_ONE  = 2'd1,
    FILT_TWO  = 2'd2,
    FILT_THREE = 2'd3
  } filter_t;

  // Last nybble of a data word.
  localparam step_t STEP_LAST = 2'd3;

  // Largest shift that scales normally; anything above is the invalid case.
  localparam logic [3:0] SHIFT_MAX = 4'd12;

  // Value a negative nybble takes under an invalid shift.
  localparam acc_t INVALID_NEG = ~acc_t'(20'h007ff);

  // Filter coefficients for the newest sample (P1) and the halved older sample (P2).
  localparam acc_t COEF_TWO_P1   = -20'sd3;
  localparam acc_t COEF_THREE_P1 = -20'sd13;
  localparam acc_t COEF_THREE_P2 = 20'sd3;

  // Clamp limits of the 16-bit signed sum.
  localparam acc_t SAT_MAX = 20'sd32767;
  localparam acc_t SAT_MIN = -20'sd32768;

endpackage

>>> sv/brr_adpcm_block_decoder_unit.sv
// Top level of the BRR ADPCM block decoder: history ring memory and the sample datapath.
// The fetch stage can take the next word while the decode stage still works on the last one;
// a single shared filter step decodes the four nybbles one after another, each using the
// sample produced just before it, and a full output register holds the last nybble back.
// Reset: synchronous, active low; clears the handshake state, the ring positions and the
// per-entry valid bits of the history memory, so the ring reads as zero at once with no sweep.
module brr_adpcm_block_decoder_unit #(
  parameter int VOICE_COUNT = 8,
  parameter int RING_LENGTH = 12
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_voice,
  input  logic [1:0]         in_filter_mode,
  input  logic [3:0]         in_shift_amount,
  input  logic [7:0]         in_data_high,
  input  logic [7:0]         in_data_low,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_sample_first,
  output logic signed [15:0] out_sample_second,
  output logic signed [15:0] out_sample_third,
  output logic signed [15:0] out_sample_fourth
);

  localparam int VW    = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
  localparam int PW    = $clog2(RING_LENGTH);
  localparam int DEPTH = VOICE_COUNT * RING_LENGTH;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [PW-1:0] RL_M1 = PW'(RING_LENGTH - 1);
  localparam logic [PW-1:0] RL_M2 = PW'(RING_LENGTH - 2);

  // History ring memory with one valid bit per entry.
  brr_pkg::sample_t ring_mem [DEPTH];
  logic [DEPTH-1:0] ring_vld_r;

  // Per-voice write position.
  logic [PW-1:0] pos_r [VOICE_COUNT];

  // Fetch stage: the accepted word waits here while its history is read.
  logic             f_valid_r;
  logic [VW-1:0]    f_voice_r;
  logic [1:0]       f_filt_r;
  logic [3:0]       f_shift_r;
  logic [15:0]      f_data_r;
  logic [PW-1:0]    f_pos_r;
  brr_pkg::sample_t rd1_r;
  brr_pkg::sample_t rd2_r;
  logic             rv1_r;
  logic             rv2_r;

  // Decode stage: one nybble per cycle, held at the last nybble while the output is full.
  logic             c_busy_r;
  brr_pkg::step_t   c_step_r;
  logic [VW-1:0]    c_voice_r;
  logic [1:0]       c_filt_r;
  logic [3:0]       c_shift_r;
  logic [15:0]      c_data_r;
  logic [PW-1:0]    c_wpos_r;
  brr_pkg::sample_t p1_r;
  brr_pkg::sample_t p2_r;
  brr_pkg::sample_t smp_r [3];

  // Output register.
  logic             out_valid_r;
  brr_pkg::sample_t out_s0_r;
  brr_pkg::sample_t out_s1_r;
  brr_pkg::sample_t out_s2_r;
  brr_pkg::sample_t out_s3_r;

  logic             c_last;
  logic             out_free;
  logic             c_adv;
  logic             c_done;
  logic             load;
  logic             accept;
  logic             fwd;
  logic [3:0]       vm;
  logic [VW-1:0]    vidx;
  logic [PW-1:0]    pos_cur;
  logic [PW:0]      pos_sum;
  logic [PW-1:0]    pos_nxt;
  logic [PW-1:0]    idx1;
  logic [PW-1:0]    idx2;
  logic [AW-1:0]    rbase;
  logic [AW-1:0]    raddr1;
  logic [AW-1:0]    raddr2;
  logic [AW-1:0]    waddr;
  logic [PW-1:0]    wpos_nxt;
  brr_pkg::sample_t p1_start;
  brr_pkg::sample_t p2_start;
  logic [3:0]       nyb;
  brr_pkg::acc_t    ext;
  brr_pkg::acc_t    scaled;
  brr_pkg::acc_t    p1x;
  brr_pkg::acc_t    p2h;
  brr_pkg::acc_t    prod_a;
  brr_pkg::acc_t    prod_b;
  brr_pkg::acc_t    sum;
  brr_pkg::sample_t clamped;
  brr_pkg::sample_t cur;

  // Handshake and stage control. The fetch stage takes a word only when it is empty and the
  // decode stage is not writing its last sample, so every read sees all earlier writes or is
  // replaced by forwarding from the decode stage.
  assign c_last   = c_busy_r && (c_step_r == brr_pkg::STEP_LAST);
  assign out_free = !out_valid_r || !out_stall;
  assign c_adv    = c_busy_r && (!c_last || out_free);
  assign c_done   = c_last && out_free;
  assign load     = f_valid_r && (!c_busy_r || c_done);
  assign in_stall = f_valid_r || c_last;
  assign accept   = in_valid && !in_stall;
  assign fwd      = c_done && (c_voice_r == f_voice_r);

  // Voice number reduced into range by repeated subtraction.
  always_comb begin
    vm = {1'b0, in_voice};
    for (int i = 0; i < 8; i++) begin
      if ({1'b0, vm} >= 5'(VOICE_COUNT)) begin
        vm = vm - 4'(VOICE_COUNT);
      end
    end
    vidx = VW'(vm);
  end

  // Ring indexes of the two previous samples and the position after this word.
  always_comb begin
    pos_cur = pos_r[vidx];
    idx1    = (pos_cur == '0) ? RL_M1 : pos_cur - PW'(1);
    idx2    = (pos_cur < PW'(2)) ? pos_cur + RL_M2 : pos_cur - PW'(2);
    pos_sum = {1'b0, pos_cur} + (PW+1)'(4);
    if (pos_sum >= (PW+1)'(RING_LENGTH)) begin
      pos_sum = pos_sum - (PW+1)'(RING_LENGTH);
    end
    pos_nxt = pos_sum[PW-1:0];
    rbase   = AW'(vidx) * AW'(RING_LENGTH);
    raddr1  = rbase + AW'(idx1);
    raddr2  = rbase + AW'(idx2);
  end

  // Write address of the sample being decoded and the following position.
  assign waddr    = AW'(c_voice_r) * AW'(RING_LENGTH) + AW'(c_wpos_r);
  assign wpos_nxt = (c_wpos_r == RL_M1) ? '0 : c_wpos_r + PW'(1);

  // Starting history for the next word: forwarded when the same voice is just finishing.
  always_comb begin
    if (fwd) begin
      p1_start = cur;
      p2_start = p1_r;
    end else begin
      p1_start = rv1_r ? rd1_r : '0;
      p2_start = rv2_r ? rd2_r : '0;
    end
  end

  // Nybble selection and scaling.
  always_comb begin
    case (c_step_r)
      2'd0:    nyb = c_data_r[15:12];
      2'd1:    nyb = c_data_r[11:8];
      2'd2:    nyb = c_data_r[7:4];
      default: nyb = c_data_r[3:0];
    endcase
    ext = brr_pkg::acc_t'(signed'({{16{nyb[3]}}, nyb}));
    if (c_shift_r <= brr_pkg::SHIFT_MAX) begin
      scaled = (ext <<< c_shift_r) >>> 1;
    end else begin
      scaled = nyb[3] ? brr_pkg::INVALID_NEG : '0;
    end
  end

  // Prediction filter, clamp and doubling.
  always_comb begin
    p1x    = brr_pkg::acc_t'(p1_r);
    p2h    = brr_pkg::acc_t'(p2_r) >>> 1;
    prod_a = '0;
    prod_b = '0;
    sum    = scaled;
    unique case (brr_pkg::filter_t'(c_filt_r))
      brr_pkg::FILT_NONE: begin
        sum = scaled;
      end
      brr_pkg::FILT_ONE: begin
        sum = scaled + (p1x >>> 1) + ((-p1x) >>> 5);
      end
      brr_pkg::FILT_TWO: begin
        prod_a = p1x * brr_pkg::COEF_TWO_P1;
        sum    = scaled + p1x - p2h + (p2h >>> 4) + (prod_a >>> 6);
      end
      brr_pkg::FILT_THREE: begin
        prod_a = p1x * brr_pkg::COEF_THREE_P1;
        prod_b = p2h * brr_pkg::COEF_THREE_P2;
        sum    = scaled + p1x - p2h + (prod_a >>> 7) + (prod_b >>> 4);
      end
      default: begin
        sum = scaled;
      end
    endcase
    if (sum > brr_pkg::SAT_MAX) begin
      clamped = 16'sh7fff;
    end else if (sum < brr_pkg::SAT_MIN) begin
      clamped = 16'sh8000;
    end else begin
      clamped = sum[15:0];
    end
    cur = {clamped[14:0], 1'b0};
  end

  // History memory: one write port for the decode stage, two registered read ports.
  always_ff @(posedge clk) begin
    if (c_adv) begin
      ring_mem[waddr] <= cur;
    end
    if (accept) begin
      rd1_r <= ring_mem[raddr1];
      rd2_r <= ring_mem[raddr2];
    end
  end

  // Valid bits of the history entries and the per-voice positions.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_vld_r <= '0;
      for (int v = 0; v < VOICE_COUNT; v++) begin
        pos_r[v] <= '0;
      end
    end else begin
      if (c_adv) begin
        ring_vld_r[waddr] <= 1'b1;
      end
      if (accept) begin
        pos_r[vidx] <= pos_nxt;
      end
    end
  end

  // Fetch stage registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else if (accept) begin
      f_valid_r <= 1'b1;
    end else if (load) begin
      f_valid_r <= 1'b0;
    end
    if (accept) begin
      f_voice_r <= vidx;
      f_filt_r  <= in_filter_mode;
      f_shift_r <= in_shift_amount;
      f_data_r  <= {in_data_high, in_data_low};
      f_pos_r   <= pos_cur;
      rv1_r     <= ring_vld_r[raddr1];
      rv2_r     <= ring_vld_r[raddr2];
    end
  end

  // Decode stage registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_busy_r <= 1'b0;
      c_step_r <= '0;
    end else if (load) begin
      c_busy_r <= 1'b1;
      c_step_r <= '0;
    end else if (c_adv) begin
      if (c_last) begin
        c_busy_r <= 1'b0;
      end else begin
        c_step_r <= c_step_r + 2'd1;
      end
    end
    if (load) begin
      c_voice_r <= f_voice_r;
      c_filt_r  <= f_filt_r;
      c_shift_r <= f_shift_r;
      c_data_r  <= f_data_r;
      c_wpos_r  <= f_pos_r;
      p1_r      <= p1_start;
      p2_r      <= p2_start;
    end else if (c_adv) begin
      c_wpos_r <= wpos_nxt;
      p1_r     <= cur;
      p2_r     <= p1_r;
    end
    if (c_adv && !c_last) begin
      smp_r[c_step_r] <= cur;
    end
  end

  // Output register: holds a finished word until the far side takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (c_done) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (c_done) begin
      out_s0_r <= smp_r[0];
      out_s1_r <= smp_r[1];
      out_s2_r <= smp_r[2];
      out_s3_r <= cur;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_sample_first  = out_s0_r;
  assign out_sample_second = out_s1_r;
  assign out_sample_third  = out_s2_r;
  assign out_sample_fourth = out_s3_r;

endmodule

>>> tb/brr_sample_checker.sv
// Checker for the BRR decoder: predicts each result word from the input channel and compares.
module brr_sample_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [2:0]         in_voice,
  input  logic [1:0]         in_filter_mode,
  input  logic [3:0]         in_shift_amount,
  input  logic [7:0]         in_data_high,
  input  logic [7:0]         in_data_low,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [15:0] out_sample_first,
  input  logic signed [15:0] out_sample_second,
  input  logic signed [15:0] out_sample_third,
  input  logic signed [15:0] out_sample_fourth,
  output int                 fail_count,
  output int                 pending_words,
  output int                 words_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VOICES     = 8;
  localparam int RING_DEPTH = 12;
  localparam int SHIFT_LIMIT = 12;
  localparam int WORD_MAX   = 32767;
  localparam int WORD_MIN   = -32768;
  localparam int BAD_SHIFT_NEG = -2048;

  typedef struct packed {
    brr_pkg::sample_t first;
    brr_pkg::sample_t second;
    brr_pkg::sample_t third;
    brr_pkg::sample_t fourth;
  } sample_word_t;

  // Private copy of the per-voice history and write positions.
  brr_pkg::sample_t voice_history [VOICES][RING_DEPTH];
  int               write_index [VOICES];
  sample_word_t     expected_words [$];
  int               fails = 0;
  int               checked = 0;

  task automatic clear_history();
    for (int v = 0; v < VOICES; v++) begin
      write_index[v] = 0;
      for (int i = 0; i < RING_DEPTH; i++) voice_history[v][i] = '0;
    end
  endtask

  // Decodes one nybble against the voice's last two samples and records the new sample.
  function automatic brr_pkg::sample_t decode_nybble(input int v, input logic [3:0] nyb,
                                                     input brr_pkg::filter_t filt,
                                                     input logic [3:0] shift);
    int               s;
    int               p1;
    int               p2;
    brr_pkg::sample_t res;
    s = $signed(nyb);
    if (int'(shift) <= SHIFT_LIMIT) begin
      s = (s <<< shift) >>> 1;
    end else begin
      s = (s < 0) ? BAD_SHIFT_NEG : 0;
    end
    p1 = voice_history[v][(write_index[v] + RING_DEPTH - 1) % RING_DEPTH];
    p2 = voice_history[v][(write_index[v] + RING_DEPTH - 2) % RING_DEPTH];
    p2 = p2 >>> 1;
    case (filt)
      brr_pkg::FILT_ONE: begin
        s += (p1 >>> 1) + ((-p1) >>> 5);
      end
      brr_pkg::FILT_TWO: begin
        s += p1 - p2 + (p2 >>> 4) + ((p1 * -3) >>> 6);
      end
      brr_pkg::FILT_THREE: begin
        s += p1 - p2 + ((p1 * -13) >>> 7) + ((p2 * 3) >>> 4);
      end
      default: ;
    endcase
    if (s > WORD_MAX) s = WORD_MAX;
    if (s < WORD_MIN) s = WORD_MIN;
    // Doubling wraps into 16 bits.
    res = brr_pkg::sample_t'(s <<< 1);
    voice_history[v][write_index[v]] = res;
    write_index[v] = (write_index[v] + 1 == RING_DEPTH) ? 0 : write_index[v] + 1;
    return res;
  endfunction

  // Works out all four samples of one data word, most significant nybble first.
  function automatic sample_word_t predict_samples(input logic [2:0] voice,
                                                   input brr_pkg::filter_t filt,
                                                   input logic [3:0] shift,
                                                   input logic [15:0] data);
    sample_word_t w;
    int           v;
    v = int'(voice) % VOICES;
    w.first  = decode_nybble(v, data[15:12], filt, shift);
    w.second = decode_nybble(v, data[11:8], filt, shift);
    w.third  = decode_nybble(v, data[7:4], filt, shift);
    w.fourth = decode_nybble(v, data[3:0], filt, shift);
    return w;
  endfunction

  task automatic compare_sample(input string name, input brr_pkg::sample_t want,
                                input brr_pkg::sample_t got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endtask

  // Watch both channels at every edge; results are matched in order.
  always @(posedge clk) begin : watch
    sample_word_t want;
    if (!rst_n) begin
      clear_history();
      expected_words.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          $error("result word arrived with none outstanding");
          fails++;
        end else begin
          want = expected_words.pop_front();
          compare_sample("sample_first", want.first, out_sample_first);
          compare_sample("sample_second", want.second, out_sample_second);
          compare_sample("sample_third", want.third, out_sample_third);
          compare_sample("sample_fourth", want.fourth, out_sample_fourth);
          checked++;
        end
      end
      if (in_valid && !in_stall) begin
        expected_words.push_back(predict_samples(in_voice,
                                                 brr_pkg::filter_t'(in_filter_mode),
                                                 in_shift_amount,
                                                 {in_data_high, in_data_low}));
      end
    end
    pending_words <= expected_words.size();
    fail_count    <= fails;
    words_checked <= checked;
  end

endmodule

>>> tb/brr_adpcm_block_decoder_unit_test.sv
// Testbench top for the BRR decoder: clock, reset, word stimulus, back-pressure and verdict.
module brr_adpcm_block_decoder_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TAIL_CYCLES  = 20;
  localparam int RANDOM_WORDS = 500;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [2:0]        in_voice = '0;
  logic [1:0]        in_filter_mode = '0;
  logic [3:0]        in_shift_amount = '0;
  logic [7:0]        in_data_high = '0;
  logic [7:0]        in_data_low = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic signed [15:0] out_sample_first;
  logic signed [15:0] out_sample_second;
  logic signed [15:0] out_sample_third;
  logic signed [15:0] out_sample_fourth;

  int fail_count;
  int pending_words;
  int words_checked;
  int send_idle_pct = 26;
  int recv_idle_pct = 56;
  int words_sent = 0;
  int directed_words = 0;

  brr_adpcm_block_decoder_unit u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_voice         (in_voice),
    .in_filter_mode   (in_filter_mode),
    .in_shift_amount  (in_shift_amount),
    .in_data_high     (in_data_high),
    .in_data_low      (in_data_low),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_sample_first (out_sample_first),
    .out_sample_second(out_sample_second),
    .out_sample_third (out_sample_third),
    .out_sample_fourth(out_sample_fourth)
  );

  brr_sample_checker u_sample_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_voice         (in_voice),
    .in_filter_mode   (in_filter_mode),
    .in_shift_amount  (in_shift_amount),
    .in_data_high     (in_data_high),
    .in_data_low      (in_data_low),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_sample_first (out_sample_first),
    .out_sample_second(out_sample_second),
    .out_sample_third (out_sample_third),
    .out_sample_fourth(out_sample_fourth),
    .fail_count       (fail_count),
    .pending_words    (pending_words),
    .words_checked    (words_checked)
  );

  always #5 clk = ~clk;

  // Receiver back-pressure, redrawn every cycle.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  // Offers one word, after a random idle gap, and returns once it has been taken.
  task automatic drive_word(input logic [2:0] voice, input brr_pkg::filter_t filt,
                            input logic [3:0] shift, input logic [7:0] hi,
                            input logic [7:0] lo);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_voice        <= voice;
    in_filter_mode  <= filt;
    in_shift_amount <= shift;
    in_data_high    <= hi;
    in_data_low     <= lo;
    do @(posedge clk); while (in_stall);
    words_sent++;
  endtask

  // Holds the input back until every outstanding result word has been seen.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_words != 0);
  endtask

  // Random words; a quarter lean towards large shifts and the feedback filters to hit the clamp.
  task automatic run_random(input int count);
    brr_pkg::filter_t filt;
    logic [3:0]       shift;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 3) == 0) begin
        filt  = brr_pkg::filter_t'($urandom_range(2, 3));
        shift = 4'($urandom_range(9, 12));
      end else begin
        filt  = brr_pkg::filter_t'($urandom_range(0, 3));
        shift = 4'($urandom_range(0, 15));
      end
      drive_word(3'($urandom_range(0, 7)), filt, shift, 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed words: nybble extremes, every filter, the shift edge and the invalid shifts.
    drive_word(3'd0, brr_pkg::FILT_NONE, 4'd0, 8'h00, 8'h00);
    drive_word(3'd0, brr_pkg::FILT_NONE, 4'd0, 8'h78, 8'hF1);
    drive_word(3'd0, brr_pkg::FILT_NONE, 4'd12, 8'h77, 8'h77);
    drive_word(3'd0, brr_pkg::FILT_THREE, 4'd12, 8'h77, 8'h77);
    drive_word(3'd0, brr_pkg::FILT_TWO, 4'd12, 8'h77, 8'h77);
    drive_word(3'd1, brr_pkg::FILT_TWO, 4'd12, 8'h88, 8'h88);
    drive_word(3'd1, brr_pkg::FILT_THREE, 4'd12, 8'h88, 8'h88);
    drive_word(3'd1, brr_pkg::FILT_ONE, 4'd12, 8'hFF, 8'hFF);
    drive_word(3'd2, brr_pkg::FILT_ONE, 4'd13, 8'h8F, 8'h07);
    drive_word(3'd2, brr_pkg::FILT_TWO, 4'd14, 8'hF0, 8'h81);
    drive_word(3'd2, brr_pkg::FILT_THREE, 4'd15, 8'h88, 8'h88);
    drive_word(3'd3, brr_pkg::FILT_NONE, 4'd15, 8'h7F, 8'h80);
    drive_word(3'd3, brr_pkg::FILT_ONE, 4'd1, 8'h19, 8'hE6);
    drive_word(3'd4, brr_pkg::FILT_THREE, 4'd11, 8'h7A, 8'h5C);
    drive_word(3'd5, brr_pkg::FILT_TWO, 4'd6, 8'hC3, 8'h3C);
    drive_word(3'd6, brr_pkg::FILT_ONE, 4'd12, 8'h7E, 8'h81);
    drive_word(3'd7, brr_pkg::FILT_THREE, 4'd12, 8'h87, 8'h78);
    // Four words on one voice run the history ring past its end.
    for (int i = 0; i < 4; i++) begin
      drive_word(3'd7, brr_pkg::FILT_TWO, 4'd10, 8'h96, 8'h69);
    end
    directed_words = words_sent;

    run_random(RANDOM_WORDS);
    drain();

    send_idle_pct = 56;
    recv_idle_pct = 26;
    run_random(RANDOM_WORDS);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(RANDOM_WORDS);
    drain();

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Run covered %0d words (%0d directed) on all eight voices, every filter and shift,",
             words_sent, directed_words);
    $display("with %0d result words compared under sender gaps and receiver stalls.",
             words_checked);
    if (fail_count == 0 && pending_words == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog well beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

>>> filelist.f
sv/brr_pkg.sv
sv/brr_adpcm_block_decoder_unit.sv
tb/brr_sample_checker.sv
tb/brr_adpcm_block_decoder_unit_test.sv
